/* sv/rtwc_pkg.sv */
// shared widths, constants and register codes of the route time window checker
package rtwc_pkg;

	// parameter defaults
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 12;

	// fixed field widths
	localparam int TIME_W   = 32;
	localparam int LOAD_W   = 24;
	localparam int WIN_W    = 20;
	localparam int DEM_W    = 16;
	localparam int SERV_W   = 16;
	localparam int CLOSE_W  = 20;
	localparam int CAP_W    = 24;

	// saturation limits
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

	// apb port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	// register word indexes
	typedef enum logic [1:0] {
		REG_DEPOT_X   = 2'd0,
		REG_DEPOT_Y   = 2'd1,
		REG_DEPOT_CLS = 2'd2,
		REG_CAPACITY  = 2'd3
	} reg_idx_t;

	// register reset values
	localparam logic [CLOSE_W-1:0] DEPOT_CLOSE_RST = {CLOSE_W{1'b1}};
	localparam logic [CAP_W-1:0]   CAPACITY_RST    = {CAP_W{1'b1}};

endpackage

/* sv/rtwc_if.sv */
// item channels: customer input and route result

interface rtwc_in_if import rtwc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] cust_x;
	logic [COORD_BITS-1:0] cust_y;
	logic [DEM_W-1:0]      demand;
	logic [WIN_W-1:0]      window_open;
	logic [WIN_W-1:0]      window_close;
	logic [SERV_W-1:0]     service_time;
	logic                  last_stop;

	modport source (
		output valid, cust_x, cust_y, demand, window_open, window_close,
		service_time, last_stop,
		input  ready
	);
	modport sink (
		input  valid, cust_x, cust_y, demand, window_open, window_close,
		service_time, last_stop,
		output ready
	);
endinterface

interface rtwc_out_if import rtwc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              feasible;
	logic [TIME_W-1:0] total_time;
	logic [LOAD_W-1:0] total_load;

	modport source (
		output valid, feasible, total_time, total_load,
		input  ready
	);
	modport sink (
		input  valid, feasible, total_time, total_load,
		output ready
	);
endinterface

/* sv/route_time_window_check.sv */
// top level: route feasibility check with time windows, capacity and depot close
// One customer item enters when the block is idle; the Euclidean leg is taken by
// a shared iterative square root unit that resolves one result bit per cycle;
// for the customer marked last_stop the same unit then also computes the leg
// back to the depot. cust.ready is high only while the sequencer is idle; a
// finished route result waits in an output register and the next item can be
// taken meanwhile. Times are unsigned with FRAC_BITS fraction bits and
// saturate at 32 bits; the load saturates at 24 bits.
module route_time_window_check import rtwc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rtwc_in_if.sink               cust,
	rtwc_out_if.source            result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int P    = COORD_BITS + 1 + FRAC_BITS;
	localparam int TW   = (WIN_W + FRAC_BITS > TIME_W) ? WIN_W + FRAC_BITS : TIME_W;
	localparam int SUMW = ((P > TIME_W) ? P : TIME_W) + 1;
	localparam int C    = COORD_BITS;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQ   = 9'b000000010,
		S_ROOT = 9'b000000100,
		S_ADD  = 9'b000001000,
		S_WAIT = 9'b000010000,
		S_SERV = 9'b000100000,
		S_RADD = 9'b001000000,
		S_DONE = 9'b010000000,
		S_HOLD = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [C-1:0]       depot_x, depot_y;
	logic [CLOSE_W-1:0] depot_close;
	logic [CAP_W-1:0]   vehicle_capacity;

	rtwc_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.depot_x          (depot_x),
		.depot_y          (depot_y),
		.depot_close      (depot_close),
		.vehicle_capacity (vehicle_capacity)
	);

	// latched item
	logic [C-1:0]      cx_q, cy_q;
	logic [DEM_W-1:0]  dem_q;
	logic [WIN_W-1:0]  wopen_q, wclose_q;
	logic [SERV_W-1:0] serv_q;
	logic              last_q;

	// route state
	logic [C-1:0]      prev_x_q, prev_y_q;
	logic [TIME_W-1:0] route_time_q;
	logic [LOAD_W-1:0] route_load_q;
	logic              still_ok_q;
	logic              at_start_q;
	logic              ret_q;

	// working values
	logic [C-1:0]      dx_q, dy_q;
	logic [TW-1:0]     t_q;

	// output register
	logic              out_valid_q;
	logic              out_feasible_q;
	logic [TIME_W-1:0] out_time_q;
	logic [LOAD_W-1:0] out_load_q;

	// shared square root unit
	logic              sq_start;
	logic              sq_done;
	logic [2*C:0]      radicand;
	logic [P-1:0]      leg;
	logic [2*C-1:0]    sq_x, sq_y;

	assign sq_x     = dx_q * dx_q;
	assign sq_y     = dy_q * dy_q;
	assign radicand = {1'b0, sq_x} + {1'b0, sq_y};
	assign sq_start = (state_q == S_SQ);

	rtwc_sqrt #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (leg)
	);

	// handshake
	logic in_acc;
	logic out_free;

	assign cust.ready = (state_q == S_IDLE);
	assign in_acc     = cust.valid && (state_q == S_IDLE);
	assign out_free   = !out_valid_q || result.ready;

	// leg start point for the incoming item
	logic [C-1:0] base_x, base_y;
	assign base_x = at_start_q ? depot_x : prev_x_q;
	assign base_y = at_start_q ? depot_y : prev_y_q;

	// time arithmetic
	logic [SUMW-1:0]   leg_sum;
	logic [SUMW-1:0]   leg_base;
	logic [TIME_W-1:0] leg_sat;
	logic [TW-1:0]     wopen_fx, wclose_fx;
	logic [TW:0]       serv_sum;
	logic [TIME_W-1:0] serv_sat;
	logic [LOAD_W:0]   load_sum;
	logic [TW-1:0]     close_fx;
	logic              feasible_d;

	assign leg_base  = (state_q == S_RADD) ? SUMW'(t_q[TIME_W-1:0])
		: (at_start_q ? '0 : SUMW'(route_time_q));
	assign leg_sum   = leg_base + SUMW'(leg);
	assign leg_sat   = (leg_sum[SUMW-1:TIME_W] != '0) ? TIME_MAX : leg_sum[TIME_W-1:0];
	assign wopen_fx  = TW'({wopen_q, {FRAC_BITS{1'b0}}});
	assign wclose_fx = TW'({wclose_q, {FRAC_BITS{1'b0}}});
	assign serv_sum  = (TW+1)'(t_q) + (TW+1)'({serv_q, {FRAC_BITS{1'b0}}});
	assign serv_sat  = (serv_sum[TW:TIME_W] != '0) ? TIME_MAX : serv_sum[TIME_W-1:0];
	assign load_sum  = {1'b0, route_load_q} + (LOAD_W+1)'(dem_q);
	assign close_fx  = TW'({depot_close, {FRAC_BITS{1'b0}}});
	assign feasible_d = still_ok_q && (t_q <= close_fx)
		&& (route_load_q <= vehicle_capacity);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_acc) state_d = S_SQ;
			S_SQ:   state_d = S_ROOT;
			S_ROOT: if (sq_done) state_d = ret_q ? S_RADD : S_ADD;
			S_ADD:  state_d = S_WAIT;
			S_WAIT: state_d = S_SERV;
			S_SERV: state_d = last_q ? S_SQ : S_IDLE;
			S_RADD: state_d = S_DONE;
			S_DONE: state_d = S_HOLD;
			S_HOLD: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control and route state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			route_time_q <= '0;
			route_load_q <= '0;
			still_ok_q   <= 1'b1;
			at_start_q   <= 1'b1;
			ret_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// result valid: set when the route result is loaded, cleared when taken
			if (state_q == S_HOLD && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: ret_q <= 1'b0;
				S_ADD: begin
					route_load_q <= load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];
				end
				S_SERV: begin
					if (t_q > wclose_fx)
						still_ok_q <= 1'b0;
					if (last_q) begin
						ret_q <= 1'b1;
					end else begin
						route_time_q <= serv_sat;
						prev_x_q     <= cx_q;
						prev_y_q     <= cy_q;
						at_start_q   <= 1'b0;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						prev_x_q     <= '0;
						prev_y_q     <= '0;
						route_time_q <= '0;
						route_load_q <= '0;
						still_ok_q   <= 1'b1;
						at_start_q   <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cx_q     <= cust.cust_x;
			cy_q     <= cust.cust_y;
			dem_q    <= cust.demand;
			wopen_q  <= cust.window_open;
			wclose_q <= cust.window_close;
			serv_q   <= cust.service_time;
			last_q   <= cust.last_stop;
			dx_q     <= (base_x > cust.cust_x) ? base_x - cust.cust_x : cust.cust_x - base_x;
			dy_q     <= (base_y > cust.cust_y) ? base_y - cust.cust_y : cust.cust_y - base_y;
		end
		case (state_q)
			S_ADD:  t_q <= TW'(leg_sat);
			S_WAIT: if (t_q < wopen_fx) t_q <= wopen_fx;
			S_SERV: begin
				t_q <= TW'(serv_sat);
				// return leg to the depot
				dx_q <= (cx_q > depot_x) ? cx_q - depot_x : depot_x - cx_q;
				dy_q <= (cy_q > depot_y) ? cy_q - depot_y : depot_y - cy_q;
			end
			S_RADD: t_q <= TW'(leg_sat);
			// load the result only once the previous one has been taken
			S_HOLD: begin
				if (out_free) begin
					out_feasible_q <= feasible_d;
					out_time_q     <= t_q[TIME_W-1:0];
					out_load_q     <= route_load_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid      = out_valid_q;
	assign result.feasible   = out_feasible_q;
	assign result.total_time = out_time_q;
	assign result.total_load = out_load_q;

endmodule

/* sv/rtwc_cfg.sv */
// apb register file: depot position, depot close time, vehicle capacity
module rtwc_cfg import rtwc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [COORD_BITS-1:0] depot_x,
	output logic [COORD_BITS-1:0] depot_y,
	output logic [CLOSE_W-1:0]    depot_close,
	output logic [CAP_W-1:0]      vehicle_capacity
);

	logic [COORD_BITS-1:0] depot_x_q;
	logic [COORD_BITS-1:0] depot_y_q;
	logic [CLOSE_W-1:0]    depot_close_q;
	logic [CAP_W-1:0]      capacity_q;
	reg_idx_t              idx;
	logic                  wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depot_x_q     <= '0;
			depot_y_q     <= '0;
			depot_close_q <= DEPOT_CLOSE_RST;
			capacity_q    <= CAPACITY_RST;
		end else if (wr_en) begin
			case (idx)
				REG_DEPOT_X:   depot_x_q     <= pwdata[COORD_BITS-1:0];
				REG_DEPOT_Y:   depot_y_q     <= pwdata[COORD_BITS-1:0];
				REG_DEPOT_CLS: depot_close_q <= pwdata[CLOSE_W-1:0];
				REG_CAPACITY:  capacity_q    <= pwdata[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_DEPOT_X:   prdata = APB_DATA_W'(depot_x_q);
			REG_DEPOT_Y:   prdata = APB_DATA_W'(depot_y_q);
			REG_DEPOT_CLS: prdata = APB_DATA_W'(depot_close_q);
			REG_CAPACITY:  prdata = APB_DATA_W'(capacity_q);
			default:       prdata = '0;
		endcase
	end

	assign depot_x          = depot_x_q;
	assign depot_y          = depot_y_q;
	assign depot_close      = depot_close_q;
	assign vehicle_capacity = capacity_q;

endmodule

/* sv/rtwc_sqrt.sv */
// iterative square root, one radicand bit pair per cycle, fixed-point result
module rtwc_sqrt import rtwc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [2*COORD_BITS:0]     radicand,
	output logic                      done,
	output logic [COORD_BITS+FRAC_BITS:0] root
);

	localparam int P    = COORD_BITS + 1 + FRAC_BITS;
	localparam int RW   = P + 1;
	localparam int CNTW = $clog2(P + 1);

	logic [2*P-1:0]  rad_q;
	logic [RW-1:0]   rem_q;
	logic [P-1:0]    root_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;

	logic [RW+1:0]   rem_sh;
	logic [RW+1:0]   trial;
	logic [RW+1:0]   diff;
	logic            take;

	// one digit step
	assign rem_sh = {rem_q, rad_q[2*P-1 -: 2]};
	assign trial  = (RW+2)'({root_q, 2'b01});
	assign take   = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(P);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNTW'(1);
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: radicand shifter, partial remainder, root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {1'b0, radicand, {(2*FRAC_BITS){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[2*P-3:0], 2'b00};
			if (take) begin
				rem_q  <= diff[RW-1:0];
				root_q <= {root_q[P-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[RW-1:0];
				root_q <= {root_q[P-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
